// File: rtl/stx_len_xor_frame_receiver_assert.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef STX_LEN_XOR_FRAME_RECEIVER_ASSERT_SVH
`define STX_LEN_XOR_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property while out of reset.
`define STX_LXF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define STX_LXF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define STX_LXF_ASSERT(lbl, clk, rst_n, prop, msg)
`define STX_LXF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/stx_lxf_pkg.sv
// Types and constants of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package stx_lxf_pkg;

  localparam int ByteW  = 8;
  localparam int PhaseW = 3;
  localparam int CfgIdxW = 1;
  localparam int TdataW = 32;

  // Phase codes of the frame parser
  localparam logic [PhaseW-1:0] PhHunt  = 3'd0;
  localparam logic [PhaseW-1:0] PhLen   = 3'd1;
  localparam logic [PhaseW-1:0] PhData  = 3'd2;
  localparam logic [PhaseW-1:0] PhCheck = 3'd3;
  localparam logic [PhaseW-1:0] PhEnd   = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStartMarker = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgEndMarker   = 1'd1;

  // Reset values of the markers
  localparam logic [ByteW-1:0] StartMarkerRst = 8'h02;
  localparam logic [ByteW-1:0] EndMarkerRst   = 8'h03;

  // Result kinds
  localparam logic KindPayload  = 1'b0;
  localparam logic KindFrameEnd = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] received_check;
    logic             check_ok;
    logic             end_ok;
    logic             frame_ok;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/stx_lxf_in_stage.sv
// Input register for received bytes.
`timescale 1ns / 1ps
`default_nettype none

module stx_lxf_in_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_valid_i,
  output logic                             s_ready_o,
  input  wire logic [stx_lxf_pkg::ByteW-1:0] s_data_i,
  input  wire logic                        take_i,
  output logic                             valid_o,
  output logic [stx_lxf_pkg::ByteW-1:0]    data_o
);

  logic                          valid_q, valid_d;
  logic [stx_lxf_pkg::ByteW-1:0] data_q;
  logic                          load;

  // Accept when empty or when the held item moves on this cycle
  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the byte until the parser takes it
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= s_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/stx_lxf_parser.sv
// Frame phase machine with marker registers and XOR checksum.
`timescale 1ns / 1ps
`default_nettype none

`include "stx_len_xor_frame_receiver_assert.svh"

module stx_lxf_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [stx_lxf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [stx_lxf_pkg::ByteW-1:0]   cfg_data_i,
  input  wire logic                          step_i,
  input  wire logic [stx_lxf_pkg::ByteW-1:0]   byte_i,
  output logic                               res_valid_o,
  output stx_lxf_pkg::result_t               res_o
);

  logic [stx_lxf_pkg::ByteW-1:0]  start_q, end_q;
  logic [stx_lxf_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [stx_lxf_pkg::ByteW-1:0]  left_q, left_d;
  logic [stx_lxf_pkg::ByteW-1:0]  length_q, length_d;
  logic [stx_lxf_pkg::ByteW-1:0]  xor_q, xor_d;
  logic [stx_lxf_pkg::ByteW-1:0]  check_q, check_d;
  logic                           ck_ok, en_ok;

  // Write marker registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= stx_lxf_pkg::StartMarkerRst;
      end_q   <= stx_lxf_pkg::EndMarkerRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stx_lxf_pkg::CfgStartMarker: start_q <= cfg_data_i;
        stx_lxf_pkg::CfgEndMarker:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ck_ok = (check_q == xor_q);
  assign en_ok = (byte_i == end_q);

  // Advance the phase for one byte and form its result in the data and end phases
  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    length_d    = length_q;
    xor_d       = xor_q;
    check_d     = check_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      stx_lxf_pkg::PhLen: begin
        length_d = byte_i;
        left_d   = byte_i;
        xor_d    = '0;
        phase_d  = (byte_i != '0) ? stx_lxf_pkg::PhData : stx_lxf_pkg::PhCheck;
      end
      stx_lxf_pkg::PhData: begin
        xor_d  = xor_q ^ byte_i;
        left_d = left_q - 1'b1;
        if (left_d == '0) begin
          phase_d = stx_lxf_pkg::PhCheck;
        end
        res_valid_o        = 1'b1;
        res_o.kind         = stx_lxf_pkg::KindPayload;
        res_o.payload_byte = byte_i;
        res_o.frame_length = length_q;
      end
      stx_lxf_pkg::PhCheck: begin
        check_d = byte_i;
        phase_d = stx_lxf_pkg::PhEnd;
      end
      stx_lxf_pkg::PhEnd: begin
        res_valid_o          = 1'b1;
        res_o.kind           = stx_lxf_pkg::KindFrameEnd;
        res_o.frame_length   = length_q;
        res_o.received_check = check_q;
        res_o.check_ok       = ck_ok;
        res_o.end_ok         = en_ok;
        res_o.frame_ok       = ck_ok && en_ok;
        phase_d              = stx_lxf_pkg::PhHunt;
      end
      default: begin
        // Hunt: drop everything but the start marker
        phase_d = (byte_i == start_q) ? stx_lxf_pkg::PhLen : stx_lxf_pkg::PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= stx_lxf_pkg::PhHunt;
      left_q   <= '0;
      length_q <= '0;
      xor_q    <= '0;
      check_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      length_q <= length_d;
      xor_q    <= xor_d;
      check_q  <= check_d;
    end
  end

  `STX_LXF_ASSERT_ALWAYS(a_rst_hunt, clk_i, !rst_ni |=> phase_q == stx_lxf_pkg::PhHunt, "phase not hunting after reset")
  `STX_LXF_ASSERT(a_data_left, clk_i, rst_ni, phase_q == stx_lxf_pkg::PhData |-> left_q != '0, "data phase with no bytes left")
  `STX_LXF_ASSERT(a_end_to_hunt, clk_i, rst_ni, (step_i && phase_q == stx_lxf_pkg::PhEnd) |=> phase_q == stx_lxf_pkg::PhHunt, "no return to hunt after end slot")

endmodule

`default_nettype wire

// File: rtl/stx_lxf_out_stage.sv
// Result register toward the output stream.
`timescale 1ns / 1ps
`default_nettype none

module stx_lxf_out_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire stx_lxf_pkg::result_t res_i,
  output logic                      free_o,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output stx_lxf_pkg::result_t      m_res_o
);

  logic                 valid_q, valid_d;
  stx_lxf_pkg::result_t res_q;

  // Free when empty or draining this cycle
  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the new result
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

`default_nettype wire

// File: rtl/stx_len_xor_frame_receiver.sv
// Top level of the STX/length/XOR frame receiver.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata: rx_byte
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata: result fields, tuser: result_kind
//   cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// One byte per cycle while the result register can take it: a byte is held in the input register,
// then the phase machine consumes it and loads the result register in the same edge.
// The phase machine steps only when the result register is empty or draining,
// so a stalled m_axis stops intake after the input register fills.
// Reset clears the phase to hunting and restores start 0x02 and end 0x03.
`timescale 1ns / 1ps
`default_nettype none

`include "stx_len_xor_frame_receiver_assert.svh"

module stx_len_xor_frame_receiver (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [stx_lxf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [stx_lxf_pkg::ByteW-1:0]   cfg_data_i,
  // Byte input
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [stx_lxf_pkg::ByteW-1:0]   s_axis_tdata,  // [7:0] rx_byte
  // Result output
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [7:0] payload_byte, [15:8] frame_length, [23:16] received_check,
  // [24] check_ok, [25] end_ok, [26] frame_ok, [31:27] zero
  output logic [stx_lxf_pkg::TdataW-1:0]       m_axis_tdata,
  output logic                                 m_axis_tuser   // [0] result_kind
);

  logic                          in_valid;
  logic [stx_lxf_pkg::ByteW-1:0] in_byte;
  logic                          out_free;
  logic                          step;
  logic                          res_valid;
  stx_lxf_pkg::result_t          res;
  stx_lxf_pkg::result_t          out_res;

  // Step the parser when a byte is held and the result slot can take it
  assign step = in_valid && out_free;

  stx_lxf_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .take_i    (step),
    .valid_o   (in_valid),
    .data_o    (in_byte)
  );

  stx_lxf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  stx_lxf_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step && res_valid),
    .res_i     (res),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (out_res)
  );

  // Pack result fields, lowest field first
  assign m_axis_tdata = {5'b0, out_res.frame_ok, out_res.end_ok, out_res.check_ok,
                         out_res.received_check, out_res.frame_length,
                         out_res.payload_byte};
  assign m_axis_tuser = out_res.kind;

  `STX_LXF_ASSERT(a_payload_flags, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser == stx_lxf_pkg::KindPayload) |-> (m_axis_tdata[26:16] == '0), "payload item carries frame-end fields")
  `STX_LXF_ASSERT(a_frame_ok, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[26] == (m_axis_tdata[24] && m_axis_tdata[25])), "frame_ok differs from check_ok and end_ok")

endmodule

`default_nettype wire

// File: dv/stx_len_xor_frame_receiver_tb.sv
// Self-checking testbench of the STX/length/XOR frame receiver.
`timescale 1ns / 1ps

module testbench;
  import stx_lxf_pkg::*;

  localparam int unsigned RandomItems = 2000;

  typedef enum logic {RowByte, RowWrite} row_op_t;

  typedef struct {
    row_op_t              op;
    logic [CfgIdxW-1:0]   reg_idx;
    logic [ByteW-1:0]     value;
    bit                   typed;
    result_t              want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [ByteW-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata = '0;    // [7:0] rx_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [7:0] payload_byte, [15:8] frame_length, [23:16] received_check,
  // [24] check_ok, [25] end_ok, [26] frame_ok
  logic [TdataW-1:0]    m_axis_tdata;
  logic                 m_axis_tuser;         // [0] result_kind

  // Mirror of the parser state and marker registers
  logic [PhaseW-1:0]    phase_q = PhHunt;
  logic [ByteW-1:0]     bytes_left_q = '0;
  logic [ByteW-1:0]     length_q = '0;
  logic [ByteW-1:0]     xor_q = '0;
  logic [ByteW-1:0]     check_q = '0;
  logic [ByteW-1:0]     start_marker_q = StartMarkerRst;
  logic [ByteW-1:0]     end_marker_q = EndMarkerRst;

  result_t              pending_results[$];
  stim_row_t            dir_rows[$];
  int unsigned          items_sent = 0;
  int unsigned          results_seen = 0;
  int unsigned          errors = 0;
  bit                   quiet = 1'b0;
  bit                   need_max_len = 1'b1;

  stx_len_xor_frame_receiver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Advance the frame parser by one byte; return the result it produces
  task automatic parse_rx_byte(input logic [ByteW-1:0] b, output bit got, output result_t r);
    r = '0;
    got = 1'b0;
    case (phase_q)
      PhLen: begin
        length_q = b;
        bytes_left_q = b;
        xor_q = '0;
        phase_q = (b != 0) ? PhData : PhCheck;
      end
      PhData: begin
        xor_q = xor_q ^ b;
        bytes_left_q = bytes_left_q - 1'b1;
        if (bytes_left_q == 0) phase_q = PhCheck;
        got = 1'b1;
        r.kind = KindPayload;
        r.payload_byte = b;
        r.frame_length = length_q;
      end
      PhCheck: begin
        check_q = b;
        phase_q = PhEnd;
      end
      PhEnd: begin
        got = 1'b1;
        r.kind = KindFrameEnd;
        r.frame_length = length_q;
        r.received_check = check_q;
        r.check_ok = (check_q == xor_q);
        r.end_ok = (b == end_marker_q);
        r.frame_ok = r.check_ok & r.end_ok;
        phase_q = PhHunt;
      end
      default: begin
        phase_q = (b == start_marker_q) ? PhLen : PhHunt;
      end
    endcase
  endtask

  // Offer one byte after a random gap, then record what it must produce
  task automatic send_byte(input logic [ByteW-1:0] b, input bit typed, input result_t want);
    int unsigned gap;
    bit got;
    result_t r;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    // bytes dropped while hunting do not count
    if (!(phase_q == PhHunt && b != start_marker_q)) items_sent++;
    parse_rx_byte(b, got, r);
    if (typed) pending_results.push_back(want);
    else if (got) pending_results.push_back(r);
  endtask

  // Drain all results and let the input register empty before a write
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Pulse the write enable for one edge, then leave the port idle before returning
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgStartMarker) start_marker_q = v;
    else end_marker_q = v;
    @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_marker(input logic [ByteW-1:0] rst_val);
    case ($urandom_range(0, 3))
      0: return rst_val;
      1: return 8'h00;
      2: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one frame with random content; a cut frame stops part way
  task automatic send_frame(input bit cut);
    logic [ByteW-1:0] seq_b[$];
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] x;
    logic [ByteW-1:0] b;
    int unsigned r;
    int unsigned keep;
    r = $urandom_range(0, 199);
    if (need_max_len || r < 2) len = 8'hFF;
    else if (r < 22) len = 8'h00;
    else len = 8'($urandom_range(1, 12));
    need_max_len = 1'b0;
    x = '0;
    seq_b.push_back(start_marker_q);
    seq_b.push_back(len);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      x = x ^ b;
      seq_b.push_back(b);
    end
    seq_b.push_back(($urandom_range(0, 9) != 0) ? x : 8'($urandom_range(0, 255)));
    seq_b.push_back(($urandom_range(0, 9) != 0) ? end_marker_q : 8'($urandom_range(0, 255)));
    keep = cut ? $urandom_range(1, seq_b.size() - 1) : seq_b.size();
    for (int i = 0; i < keep; i++) send_byte(seq_b[i], 1'b0, '0);
  endtask

  function automatic stim_row_t row_b(input logic [ByteW-1:0] b);
    stim_row_t row;
    row = '{RowByte, CfgStartMarker, b, 1'b0, '0};
    return row;
  endfunction

  function automatic stim_row_t row_r(input logic [ByteW-1:0] b, input result_t want);
    stim_row_t row;
    row = '{RowByte, CfgStartMarker, b, 1'b1, want};
    return row;
  endfunction

  function automatic stim_row_t row_w(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] v);
    stim_row_t row;
    row = '{RowWrite, idx, v, 1'b0, '0};
    return row;
  endfunction

  function automatic result_t end_res(input logic [ByteW-1:0] len, input logic [ByteW-1:0] chk,
                                      input logic ck, input logic en);
    result_t r;
    r = '{KindFrameEnd, 8'h00, len, chk, ck, en, ck & en};
    return r;
  endfunction

  // Stimulus: directed table, then random phases
  initial begin
    int unsigned target;
    int unsigned phase_end;
    int unsigned r;
    // reset markers: empty frame, one byte of all ones
    dir_rows.push_back(row_b(8'h00));
    dir_rows.push_back(row_b(8'h02));
    dir_rows.push_back(row_b(8'h00));
    dir_rows.push_back(row_b(8'h00));
    dir_rows.push_back(row_r(8'h03, end_res(8'h00, 8'h00, 1'b1, 1'b1)));
    dir_rows.push_back(row_b(8'h02));
    dir_rows.push_back(row_b(8'h01));
    dir_rows.push_back(row_r(8'hFF, '{KindPayload, 8'hFF, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0}));
    dir_rows.push_back(row_b(8'hFF));
    dir_rows.push_back(row_r(8'h03, end_res(8'h01, 8'hFF, 1'b1, 1'b1)));
    // start marker as length and as data, bad checksum and bad end slot
    dir_rows.push_back(row_b(8'h02));
    dir_rows.push_back(row_b(8'h02));
    dir_rows.push_back(row_b(8'h02));
    dir_rows.push_back(row_b(8'h55));
    dir_rows.push_back(row_b(8'h00));
    dir_rows.push_back(row_r(8'hFF, end_res(8'h02, 8'h00, 1'b0, 1'b0)));
    // extreme markers
    dir_rows.push_back(row_w(CfgStartMarker, 8'hFF));
    dir_rows.push_back(row_w(CfgEndMarker, 8'h00));
    dir_rows.push_back(row_b(8'h02));
    dir_rows.push_back(row_b(8'hFF));
    dir_rows.push_back(row_b(8'h01));
    dir_rows.push_back(row_b(8'h80));
    dir_rows.push_back(row_b(8'h80));
    dir_rows.push_back(row_r(8'h00, end_res(8'h01, 8'h80, 1'b1, 1'b1)));
    dir_rows.push_back(row_w(CfgStartMarker, 8'h00));
    dir_rows.push_back(row_w(CfgEndMarker, 8'hFF));
    // empty frame with a nonzero checksum
    dir_rows.push_back(row_b(8'h00));
    dir_rows.push_back(row_b(8'h00));
    dir_rows.push_back(row_b(8'h01));
    dir_rows.push_back(row_r(8'hFF, end_res(8'h00, 8'h01, 1'b0, 1'b1)));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == RowWrite) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_byte(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random phases; a phase may end mid-frame, so writes also land mid-frame
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      settle();
      if ($urandom_range(0, 1)) write_reg(CfgStartMarker, pick_marker(StartMarkerRst));
      if ($urandom_range(0, 1)) write_reg(CfgEndMarker, pick_marker(EndMarkerRst));
      quiet = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + $urandom_range(30, 200);
      while (items_sent < phase_end && items_sent < target) begin
        r = $urandom_range(0, 9);
        if (r < 8) begin
          send_frame(1'b0);
        end else if (r == 8) begin
          repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
          send_frame(1'b1);
        end
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off to fill the block
  initial begin
    int unsigned stall;
    bit held;
    held = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && results_seen >= 100) begin
        held = 1'b1;
        stall = 300;
      end else begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: tuser %0h tdata %0h", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.kind, m_axis_tuser);
        check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
        check_field("frame_length", want.frame_length, m_axis_tdata[15:8]);
        check_field("received_check", want.received_check, m_axis_tdata[23:16]);
        check_field("check_ok", want.check_ok, m_axis_tdata[24]);
        check_field("end_ok", want.end_ok, m_axis_tdata[25]);
        check_field("frame_ok", want.frame_ok, m_axis_tdata[26]);
      end
    end
  end

  // Give up on a hung run
  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/stx_lxf_pkg.sv
rtl/stx_lxf_in_stage.sv
rtl/stx_lxf_parser.sv
rtl/stx_lxf_out_stage.sv
rtl/stx_len_xor_frame_receiver.sv
dv/stx_len_xor_frame_receiver_tb.sv
